@@ hdl/sips_pkg.sv @@
// Shared types and constants for the SCSI initiator phase sequencer.
// No dependencies; compiled first.
package sips_pkg;

    // Store geometry
    localparam int CDB_DEPTH = 16;
    localparam int OUT_DEPTH = 128;
    localparam int CDB_AW    = $clog2(CDB_DEPTH);
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    // Field widths fixed by the bus and the item layout
    localparam int POS_W = 7;
    localparam int CNT_W = 20;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Register reset values
    localparam logic [2:0]       TARGET_ID_RST = 3'd0;
    localparam logic [CNT_W-1:0] BUSY_TMO_RST  = 20'd100000;
    localparam logic [7:0]       SETTLE_RST    = 8'd60;
    localparam logic [15:0]      RECOVERY_RST  = 16'd4000;

    // Initiator bit of the selection ID pattern
    localparam logic [7:0] INIT_ID_BIT = 8'h80;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_LOAD_CDB = 2'd1,
        CMD_LOAD_OUT = 2'd2,
        CMD_START    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_TARGET_ID    = 2'd0,
        CFG_BUSY_TIMEOUT = 2'd1,
        CFG_SETTLE       = 2'd2,
        CFG_RECOVERY     = 2'd3
    } t_cfg_idx;

    // Phase codes
    localparam logic [2:0] PH_DATA_OUT = 3'd0;
    localparam logic [2:0] PH_DATA_IN  = 3'd1;
    localparam logic [2:0] PH_COMMAND  = 3'd2;
    localparam logic [2:0] PH_STATUS   = 3'd3;
    localparam logic [2:0] PH_MSG_IN   = 3'd7;

    // Received byte kinds
    localparam logic [1:0] RX_DATA   = 2'd0;
    localparam logic [1:0] RX_STATUS = 2'd1;
    localparam logic [1:0] RX_MSG    = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BUS_BUSY  = 2'd1;
    localparam logic [1:0] ERR_NO_SELECT = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [POS_W-1:0] load_index;
        logic [7:0]       load_byte;
        logic             bus_busy;
        logic             bus_req;
        logic             bus_msg;
        logic             bus_cd;
        logic             bus_io;
        logic             phase_match;
        logic [7:0]       bus_data_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       data_drive;
        logic             drive_enable;
        logic             assert_sel;
        logic             assert_ack;
        logic [2:0]       target_phase;
        logic             rx_valid;
        logic [1:0]       rx_kind;
        logic [POS_W-1:0] rx_index;
        logic [7:0]       rx_byte;
        logic             done_res;
        logic [1:0]       error_code;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       index;
        logic [CNT_W-1:0] wdata;
    } t_cfg_word;

endpackage

@@ hdl/sips_ifs.sv @@
// Valid/ready channel interfaces: input words, result words, register writes.
// Depends on sips_pkg.
interface sips_in_if;
    logic               valid;
    logic               ready;
    sips_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sips_out_if;
    logic                valid;
    logic                ready;
    sips_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sips_cfg_if;
    logic                valid;
    logic                ready;
    sips_pkg::t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/scsi_initiator_phase_sequencer_core.sv @@
// SCSI initiator phase sequencer: selection, phase decode, REQ/ACK transfer.
// Depends on sips_pkg and the channel interfaces in sips_ifs.sv.
//
//  channel  | dir | word                      | taken when
//  ---------+-----+---------------------------+------------------------
//  i_cfg    | in  | register index, wdata     | valid (ready tied high)
//  i_in     | in  | command, load, bus sample | valid & ready
//  o_out    | out | bus drive, rx byte, done  | valid & ready
//
// One word in per cycle unless the output stalls, one result per word. A
// result goes via stage 1 to the output register; stage 0 runs the
// sequencer and issues the store read, stage 1 gets the registered read data.
// Reset is synchronous; the store valid bits clear in the same cycle, so no
// clearing pass is needed. A stalled output holds stage 1 and then i_in.
module scsi_initiator_phase_sequencer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sips_cfg_if.sink   i_cfg,
    sips_in_if.sink    i_in,
    sips_out_if.source o_out
);
    import sips_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BUSWAIT, ST_ARB, ST_SELWAIT, ST_SELHOLD,
        ST_SELPOST, ST_DECODE, ST_XFER, ST_ACKW, ST_RECOV
    } t_state;

    // which source fills data_drive once the store read returns
    typedef enum logic [1:0] {DRV_NONE, DRV_ID, DRV_CDB, DRV_OUT} t_drv_sel;

    typedef struct packed {
        t_out_item item;   // data_drive carries the ID pattern
        t_drv_sel  drv_sel;
    } t_s1;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic [2:0]       r_target_id;
    logic [CNT_W-1:0] r_busy_tmo;
    logic [7:0]       r_settle;
    logic [15:0]      r_recovery;

    t_state           r_state,  n_state;
    logic [CNT_W-1:0] r_cnt,    n_cnt;
    logic [POS_W-1:0] r_pos,    n_pos;
    logic [2:0]       r_phase,  n_phase;

    logic             r_s1_vld;
    t_s1              r_s1,     n_s1;
    logic             r_o_vld;
    t_out_item        r_o,      n_o;

    // Stores, their valid bits and registered read ports
    logic [7:0]           cdb_mem [CDB_DEPTH];
    logic [7:0]           out_mem [OUT_DEPTH];
    logic [CDB_DEPTH-1:0] r_cdb_vld;
    logic [OUT_DEPTH-1:0] r_out_vld;
    logic [7:0]           r_cdb_q, r_out_q, r_fwd_byte;
    logic                 r_cdb_qv, r_out_qv, r_cdb_fwd, r_out_fwd;

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic o_free, s1_adv, in_rdy, in_acc;

    assign o_free   = !r_o_vld || o_out.ready;
    assign s1_adv   = r_s1_vld && o_free;
    assign in_rdy   = !r_s1_vld || o_free;
    assign in_acc   = i_in.valid && in_rdy;

    assign i_in.ready  = in_rdy;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_o_vld;
    assign o_out.data  = r_o;

    // ---------------------------------------------------------------
    // Stage 0: sequencer step
    // ---------------------------------------------------------------
    t_cmd             cmd;
    logic [CNT_W-1:0] limit, cnt_inc;
    logic             cnt_over;
    logic             cdb_wr, out_wr;
    logic [CDB_AW-1:0] cdb_waddr, cdb_raddr;
    logic [OUT_AW-1:0] out_waddr, out_raddr;

    assign cmd     = t_cmd'(i_in.data.command);
    assign cnt_inc = r_cnt + 1'b1;

    // delay limit for whichever counted wait the state is in
    always_comb begin
        case (r_state)
            ST_BUSWAIT, ST_SELWAIT:        limit = r_busy_tmo;
            ST_ARB, ST_SELHOLD, ST_SELPOST: limit = CNT_W'(r_settle);
            ST_RECOV:                      limit = CNT_W'(r_recovery);
            default:                       limit = '0;
        endcase
    end
    assign cnt_over = r_cnt >= limit;

    always_comb begin
        logic is_out;
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_phase = r_phase;
        n_s1    = '0;
        is_out  = (r_phase == PH_DATA_OUT) || (r_phase == PH_COMMAND);

        case (cmd)
            CMD_LOAD_CDB, CMD_LOAD_OUT: begin
                // store write only, sequencer holds
            end
            CMD_START: begin
                if (r_state == ST_IDLE) begin
                    n_state = ST_BUSWAIT;
                    n_cnt   = '0;
                end
            end
            CMD_TICK: begin
                case (r_state)
                    ST_IDLE: begin
                    end
                    ST_BUSWAIT: begin
                        if (i_in.data.bus_busy) begin
                            if (cnt_over) begin
                                n_s1.item.done_res   = 1'b1;
                                n_s1.item.error_code = ERR_BUS_BUSY;
                                n_state = ST_IDLE;
                            end else begin
                                n_cnt = cnt_inc;
                            end
                        end else begin
                            n_state = ST_ARB;
                            n_cnt   = '0;
                        end
                    end
                    ST_ARB, ST_SELHOLD, ST_SELPOST: begin
                        if (cnt_over) begin
                            n_cnt = '0;
                            case (r_state)
                                ST_ARB:     n_state = ST_SELWAIT;
                                ST_SELHOLD: n_state = ST_SELPOST;
                                default:    n_state = ST_DECODE;
                            endcase
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    ST_SELWAIT: begin
                        if (i_in.data.bus_busy) begin
                            n_state = ST_SELHOLD;
                            n_cnt   = '0;
                        end else if (cnt_over) begin
                            n_s1.item.done_res   = 1'b1;
                            n_s1.item.error_code = ERR_NO_SELECT;
                            n_state = ST_IDLE;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    ST_DECODE: begin
                        if (!i_in.data.bus_busy) begin
                            n_s1.item.done_res = 1'b1;
                            n_state = ST_IDLE;
                        end else if (i_in.data.bus_req || !i_in.data.phase_match) begin
                            // message-out: nothing taken, decode again
                            if (!(i_in.data.bus_cd && i_in.data.bus_msg && !i_in.data.bus_io))
                            begin
                                if (i_in.data.bus_cd) begin
                                    if (i_in.data.bus_msg)  n_phase = PH_MSG_IN;
                                    else if (i_in.data.bus_io) n_phase = PH_STATUS;
                                    else                    n_phase = PH_COMMAND;
                                end else begin
                                    n_phase = i_in.data.bus_io ? PH_DATA_IN : PH_DATA_OUT;
                                end
                                n_pos   = '0;
                                n_state = ST_XFER;
                            end
                        end
                    end
                    ST_XFER: begin
                        if (!i_in.data.phase_match || !i_in.data.bus_busy) begin
                            n_state = ST_DECODE;
                        end else if (i_in.data.bus_req) begin
                            if (!is_out) begin
                                n_s1.item.rx_valid = 1'b1;
                                n_s1.item.rx_index = r_pos;
                                n_s1.item.rx_byte  = i_in.data.bus_data_in;
                                if (r_phase == PH_DATA_IN)     n_s1.item.rx_kind = RX_DATA;
                                else if (r_phase == PH_STATUS) n_s1.item.rx_kind = RX_STATUS;
                                else                           n_s1.item.rx_kind = RX_MSG;
                            end
                            n_state = ST_ACKW;
                        end
                    end
                    ST_ACKW: begin
                        // BSY loss releases ACK like a dropped REQ
                        if (!i_in.data.bus_req || !i_in.data.bus_busy) begin
                            n_state = ST_RECOV;
                            n_cnt   = '0;
                            if (r_pos < POS_MAX) n_pos = r_pos + 1'b1;
                        end
                    end
                    ST_RECOV: begin
                        if (cnt_over) n_state = ST_XFER;
                        else          n_cnt = cnt_inc;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            default: begin
            end
        endcase

        // bus outputs follow the state after the step
        n_s1.drv_sel = DRV_NONE;
        if (n_state inside {ST_ARB, ST_SELWAIT, ST_SELHOLD, ST_SELPOST}) begin
            n_s1.drv_sel           = DRV_ID;
            n_s1.item.data_drive   = INIT_ID_BIT | (8'd1 << r_target_id);
            n_s1.item.drive_enable = 1'b1;
            n_s1.item.assert_sel   = (n_state == ST_SELWAIT) || (n_state == ST_SELHOLD);
        end else if (n_state inside {ST_XFER, ST_ACKW, ST_RECOV}) begin
            n_s1.item.target_phase = n_phase;
            n_s1.item.assert_ack   = (n_state == ST_ACKW);
            if (n_state != ST_RECOV) begin
                if (n_phase == PH_COMMAND) begin
                    n_s1.item.drive_enable = 1'b1;
                    // past the CDB store the bus is driven with zero
                    if (int'(n_pos) < CDB_DEPTH) n_s1.drv_sel = DRV_CDB;
                end else if (n_phase == PH_DATA_OUT) begin
                    n_s1.item.drive_enable = 1'b1;
                    if (int'(n_pos) < OUT_DEPTH) n_s1.drv_sel = DRV_OUT;
                end
            end
        end
    end

    // store write and read ports
    assign cdb_wr    = in_acc && (cmd == CMD_LOAD_CDB)
                       && (int'(i_in.data.load_index) < CDB_DEPTH);
    assign out_wr    = in_acc && (cmd == CMD_LOAD_OUT)
                       && (int'(i_in.data.load_index) < OUT_DEPTH);
    assign cdb_waddr = CDB_AW'(i_in.data.load_index);
    assign out_waddr = OUT_AW'(i_in.data.load_index);
    assign cdb_raddr = CDB_AW'(n_pos);
    assign out_raddr = OUT_AW'(n_pos);

    // ---------------------------------------------------------------
    // Stage 1: merge store data into the result word
    // ---------------------------------------------------------------
    always_comb begin
        logic [7:0] cdb_byte, out_byte;
        cdb_byte = r_cdb_fwd ? r_fwd_byte : (r_cdb_qv ? r_cdb_q : 8'd0);
        out_byte = r_out_fwd ? r_fwd_byte : (r_out_qv ? r_out_q : 8'd0);
        n_o = r_s1.item;
        case (r_s1.drv_sel)
            DRV_ID:  n_o.data_drive = r_s1.item.data_drive;
            DRV_CDB: n_o.data_drive = cdb_byte;
            DRV_OUT: n_o.data_drive = out_byte;
            default: n_o.data_drive = 8'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer state, configuration and pipeline registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_id <= TARGET_ID_RST;
            r_busy_tmo  <= BUSY_TMO_RST;
            r_settle    <= SETTLE_RST;
            r_recovery  <= RECOVERY_RST;
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_phase     <= PH_DATA_OUT;
            r_s1_vld    <= 1'b0;
            r_o_vld     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (t_cfg_idx'(i_cfg.data.index))
                    CFG_TARGET_ID:    r_target_id <= i_cfg.data.wdata[2:0];
                    CFG_BUSY_TIMEOUT: r_busy_tmo  <= i_cfg.data.wdata;
                    CFG_SETTLE:       r_settle    <= i_cfg.data.wdata[7:0];
                    CFG_RECOVERY:     r_recovery  <= i_cfg.data.wdata[15:0];
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_state <= n_state;
                r_cnt   <= n_cnt;
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_s1    <= n_s1;
            end
            if (in_rdy) r_s1_vld <= in_acc;
            if (o_free) r_o_vld  <= r_s1_vld;
            if (s1_adv) r_o      <= n_o;
        end
    end

    // Store valid bits: an entry never loaded reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cdb_vld <= '0;
            r_out_vld <= '0;
        end else begin
            if (cdb_wr) r_cdb_vld[cdb_waddr] <= 1'b1;
            if (out_wr) r_out_vld[out_waddr] <= 1'b1;
        end
    end

    // Store arrays; the read port sees old data on a same-entry write,
    // so the load byte is forwarded instead
    always_ff @(posedge i_clk) begin
        if (cdb_wr) cdb_mem[cdb_waddr] <= i_in.data.load_byte;
        if (out_wr) out_mem[out_waddr] <= i_in.data.load_byte;
        if (in_acc) begin
            r_cdb_q    <= cdb_mem[cdb_raddr];
            r_out_q    <= out_mem[out_raddr];
            r_cdb_qv   <= r_cdb_vld[cdb_raddr];
            r_out_qv   <= r_out_vld[out_raddr];
            r_cdb_fwd  <= cdb_wr && (cdb_waddr == cdb_raddr);
            r_out_fwd  <= out_wr && (out_waddr == out_raddr);
            r_fwd_byte <= i_in.data.load_byte;
        end
    end

`ifndef SYNTHESIS
    // SEL is only raised while the ID pattern is on the bus
    a_sel_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.assert_sel |-> o_out.data.drive_enable)
        else $error("SEL asserted without data bus drive");

    // an error code only comes with the end of a transaction
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.data.error_code != ERR_NONE) |-> o_out.data.done_res)
        else $error("error code outside transaction end");

    // a received byte is acknowledged, never driven back
    a_rx_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.rx_valid |->
            o_out.data.assert_ack && !o_out.data.drive_enable)
        else $error("received byte without ACK or with bus drive");

    // every taken word occupies stage 1 on the next cycle
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_vld)
        else $error("accepted word lost before stage 1");
`endif

endmodule
